// ===== hw/rtl/tfc_pkg.sv =====
// shared types and constants of the timecode frame converter
package tfc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FPS_NUM      = 3'd0,
    CFG_FPS_DEN      = 3'd1,
    CFG_ROUNDED_FPS  = 3'd2,
    CFG_DROP_FRAME   = 3'd3,
    CFG_DROP_PER_MIN = 3'd4
  } cfg_idx_e;

  localparam int InDataW  = 64;
  localparam int OutDataW = 80;
  localparam int CfgDataW = 20;

  // largest magnitude of a combined count
  localparam logic signed [40:0] CntMaxW = 41'sd2147483647;

  // fields that ride along the divider chain
  typedef struct packed {
    logic               func;
    logic               neg;
    logic               tcneg;
    logic [9:0]         ff;
    logic [28:0]        rsecs;
    logic [16:0]        dsub;
    logic signed [40:0] cntw;
    logic [19:0]        hours;
    logic [5:0]         mins;
    logic [5:0]         secs;
  } side_t;

endpackage

// ===== hw/rtl/timecode_frame_converter_unit.sv =====
// timecode frame converter: one transfer per cycle while the output buffer has room; the path
// from input transfer to output valid runs through a chain of six bit-per-stage dividers
// (146 stages), seven arithmetic stages and the output register, the stages advancing together
// a two-entry output buffer keeps s_axis_tready registered; it drops only when full
// reset clears all valid bits and loads the configuration defaults
// (30/1 rate, rounded rate 30, non-drop, two dropped frames per minute)
module timecode_frame_converter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // frame_count_in[31:0], tc_negative[32], tc_hours[39:33], tc_minutes[46:40],
  // tc_seconds[53:47], tc_frames[63:54]
  input  logic [tfc_pkg::InDataW-1:0]    s_axis_tdata,
  // func[0]
  input  logic                           s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // frame_count_out[31:0], out_negative[32], out_hours[52:33], out_minutes[58:53],
  // out_seconds[64:59], out_frames[74:65], drop_separator[75],
  // three_digit_frames[76], zero[79:77]
  output logic [tfc_pkg::OutDataW-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [tfc_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import tfc_pkg::*;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [19:0] fps_num_q;
  logic [15:0] fps_den_q;
  logic [9:0]  rfps_q;
  logic        drop_q;
  logic [3:0]  dpm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_num_q <= 20'd30;
      fps_den_q <= 16'd1;
      rfps_q    <= 10'd30;
      drop_q    <= 1'b0;
      dpm_q     <= 4'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FPS_NUM:      fps_num_q <= cfg_wdata_i;
        CFG_FPS_DEN:      fps_den_q <= cfg_wdata_i[15:0];
        CFG_ROUNDED_FPS:  rfps_q    <= cfg_wdata_i[9:0];
        CFG_DROP_FRAME:   drop_q    <= cfg_wdata_i[0];
        CFG_DROP_PER_MIN: dpm_q     <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // derived rate constants, refreshed every cycle; a zero rate counts as one
  logic [19:0] nz_w;
  logic [15:0] dz_w;
  logic [19:0] nz_q;
  logic [15:0] dz_q;
  logic [31:0] y_q;     // frames per hour times den
  logic [25:0] n60_q;   // frames per minute times den
  logic        tdf_q;   // rate above one hundred

  assign nz_w = (fps_num_q == '0) ? 20'd1 : fps_num_q;
  assign dz_w = (fps_den_q == '0) ? 16'd1 : fps_den_q;

  always_ff @(posedge clk_i) begin
    nz_q  <= nz_w;
    dz_q  <= dz_w;
    y_q   <= 32'(nz_w) * 32'd3600;
    n60_q <= 26'(nz_w) * 26'd60;
    tdf_q <= (23'(nz_w) > (23'(dz_w) * 23'd100));
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: everything moves unless the output buffer is full
  // ---------------------------------------------------------------------------
  logic en;
  logic out_v_q, spare_v_q;
  assign en            = !spare_v_q;
  assign s_axis_tready = en;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // stage a: magnitude, seconds and total minutes of the timecode
  // ---------------------------------------------------------------------------
  logic        a_v_q;
  logic        a_func_q, a_neg_q, a_tcneg_q;
  logic [31:0] a_m_q;
  logic [18:0] a_secs_q;
  logic [12:0] a_tm_q;
  logic [9:0]  a_ff_q;

  logic [31:0] in_raw;
  logic [6:0]  in_hh, in_mm, in_ss;
  assign in_raw = s_axis_tdata[31:0];
  assign in_hh  = s_axis_tdata[39:33];
  assign in_mm  = s_axis_tdata[46:40];
  assign in_ss  = s_axis_tdata[53:47];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_func_q  <= s_axis_tuser;
      a_neg_q   <= in_raw[31];
      // most negative count maps onto 2**31, which still fits
      a_m_q     <= in_raw[31] ? (~in_raw + 32'd1) : in_raw;
      a_secs_q  <= 19'(in_hh) * 19'd3600 + 19'(in_mm) * 19'd60 + 19'(in_ss);
      a_tm_q    <= 13'(in_hh) * 13'd60 + 13'(in_mm);
      a_ff_q    <= s_axis_tdata[63:54];
      a_tcneg_q <= s_axis_tdata[32];
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: products and tenth-minute count
  // ---------------------------------------------------------------------------
  logic        b_v_q;
  logic        b_func_q, b_neg_q, b_tcneg_q;
  logic [47:0] b_md_q;
  logic [38:0] b_p_q;
  logic [28:0] b_rsecs_q;
  logic [12:0] b_tm_q;
  logic [9:0]  b_tm10_q;
  logic [9:0]  b_ff_q;
  logic [25:0] tm_scaled;

  // tm / 10 by reciprocal, exact for tm below 7750
  assign tm_scaled = 26'(a_tm_q) * 26'd6554;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_func_q  <= a_func_q;
      b_neg_q   <= a_neg_q;
      b_tcneg_q <= a_tcneg_q;
      b_md_q    <= 48'(a_m_q) * 48'(dz_q);
      b_p_q     <= 39'(a_secs_q) * 39'(nz_q);
      b_rsecs_q <= 29'(a_secs_q) * 29'(rfps_q);
      b_tm_q    <= a_tm_q;
      b_tm10_q  <= tm_scaled[25:16];
      b_ff_q    <= a_ff_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: dropped frame total and first divider operands
  // ---------------------------------------------------------------------------
  logic        c_v_q;
  logic [47:0] c_num_q;
  logic [31:0] c_den_q;
  side_t       c_side_q;
  side_t       c_side_d;
  logic [12:0] tm_kept;

  assign tm_kept = b_tm_q - 13'(b_tm10_q);

  always_comb begin
    c_side_d       = '0;
    c_side_d.func  = b_func_q;
    c_side_d.neg   = b_neg_q;
    c_side_d.tcneg = b_tcneg_q;
    c_side_d.ff    = b_ff_q;
    c_side_d.rsecs = b_rsecs_q;
    c_side_d.dsub  = 17'(dpm_q) * 17'(tm_kept);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // timecode direction divides seconds times rate by den, split divides by hour length
      c_num_q  <= b_func_q ? 48'(b_p_q) : b_md_q;
      c_den_q  <= b_func_q ? 32'(dz_q) : y_q;
      c_side_q <= c_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // divider 1: hours, or whole frames of the timecode
  // ---------------------------------------------------------------------------
  logic        d1_v;
  logic [38:0] d1_q;
  logic [31:0] d1_r;
  side_t       d1_side;

  tfc_div #(.NW(48), .DW(32), .QW(39)) u_div_hours (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_v_q),
    .num_i   (c_num_q),
    .den_i   (c_den_q),
    .side_i  (c_side_q),
    .valid_o (d1_v),
    .quo_o   (d1_q),
    .rem_o   (d1_r),
    .side_o  (d1_side)
  );

  // ---------------------------------------------------------------------------
  // stage e: combined count, rounded or drop-frame, and ceiling numerator for the frames that the hours split left
  // ---------------------------------------------------------------------------
  logic        e_v_q;
  logic [32:0] e_num_q;
  side_t       e_side_q;
  side_t       e_side_d;
  logic        rnd_up;
  logic [40:0] cnt_nd, cnt_df;

  assign rnd_up = ({d1_r, 1'b0} >= 33'(dz_q));
  assign cnt_nd = 41'(d1_q) + 41'(rnd_up) + 41'(d1_side.ff);
  assign cnt_df = 41'(d1_side.rsecs) + 41'(d1_side.ff) - 41'(d1_side.dsub);

  always_comb begin
    e_side_d       = d1_side;
    e_side_d.hours = d1_q[19:0];
    e_side_d.cntw  = drop_q ? cnt_df : cnt_nd;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_num_q  <= 33'(d1_r) + 33'(dz_q) - 33'd1;
      e_side_q <= e_side_d;
    end
  end

  // divider 2: frames left after hours, as the ceiling of remainder over den
  logic        d2_v;
  logic [31:0] d2_q;
  side_t       d2_side;

  tfc_div #(.NW(33), .DW(16), .QW(32)) u_div_after_hours (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_v_q),
    .num_i   (e_num_q),
    .den_i   (dz_q),
    .side_i  (e_side_q),
    .valid_o (d2_v),
    .quo_o   (d2_q),
    .rem_o   (),
    .side_o  (d2_side)
  );

  // ---------------------------------------------------------------------------
  // stage g: saturate and sign the combined count, scale frames left by den
  // ---------------------------------------------------------------------------
  logic        g_v_q;
  logic [47:0] g_prod_q;
  side_t       g_side_q;
  side_t       g_side_d;

  always_comb begin
    logic signed [40:0] w;
    logic signed [40:0] sat;
    w = d2_side.cntw;
    if (w > CntMaxW) begin
      sat = CntMaxW;
    end else if (w < -CntMaxW) begin
      sat = -CntMaxW;
    end else begin
      sat = w;
    end
    if (d2_side.tcneg) begin
      sat = -sat;
    end
    g_side_d      = d2_side;
    g_side_d.cntw = sat;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_prod_q <= 48'(d2_q) * 48'(dz_q);
      g_side_q <= g_side_d;
    end
  end

  // divider 3: minutes
  logic        d3_v;
  logic [11:0] d3_q;
  logic [25:0] d3_r;
  side_t       d3_side;

  tfc_div #(.NW(48), .DW(26), .QW(12)) u_div_minutes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_v_q),
    .num_i   (g_prod_q),
    .den_i   (n60_q),
    .side_i  (g_side_q),
    .valid_o (d3_v),
    .quo_o   (d3_q),
    .rem_o   (d3_r),
    .side_o  (d3_side)
  );

  // stage h: ceiling numerator for frames left after minutes
  logic        h_v_q;
  logic [26:0] h_num_q;
  side_t       h_side_q;
  side_t       h_side_d;

  always_comb begin
    h_side_d      = d3_side;
    h_side_d.mins = d3_q[5:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_num_q  <= 27'(d3_r) + 27'(dz_q) - 27'd1;
      h_side_q <= h_side_d;
    end
  end

  // divider 4: frames left after minutes
  logic        d4_v;
  logic [25:0] d4_q;
  side_t       d4_side;

  tfc_div #(.NW(27), .DW(16), .QW(26)) u_div_after_minutes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_v_q),
    .num_i   (h_num_q),
    .den_i   (dz_q),
    .side_i  (h_side_q),
    .valid_o (d4_v),
    .quo_o   (d4_q),
    .rem_o   (),
    .side_o  (d4_side)
  );

  // stage i: scale by den for the seconds split
  logic        i_v_q;
  logic [41:0] i_prod_q;
  side_t       i_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_prod_q <= 42'(d4_q) * 42'(dz_q);
      i_side_q <= d4_side;
    end
  end

  // divider 5: seconds
  logic        d5_v;
  logic [16:0] d5_q;
  logic [19:0] d5_r;
  side_t       d5_side;
  side_t       d5_side_upd;

  tfc_div #(.NW(42), .DW(20), .QW(17)) u_div_seconds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (i_v_q),
    .num_i   (i_prod_q),
    .den_i   (nz_q),
    .side_i  (i_side_q),
    .valid_o (d5_v),
    .quo_o   (d5_q),
    .rem_o   (d5_r),
    .side_o  (d5_side)
  );

  always_comb begin
    d5_side_upd      = d5_side;
    d5_side_upd.secs = d5_q[5:0];
  end

  // divider 6: leftover frames, floor of the seconds remainder over den
  logic        d6_v;
  logic [19:0] d6_q;
  side_t       d6_side;

  tfc_div #(.NW(21), .DW(16), .QW(20)) u_div_frames (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d5_v),
    .num_i   ({1'b0, d5_r}),
    .den_i   (dz_q),
    .side_i  (d5_side_upd),
    .valid_o (d6_v),
    .quo_o   (d6_q),
    .rem_o   (),
    .side_o  (d6_side)
  );

  // ---------------------------------------------------------------------------
  // valid bits of the arithmetic stages
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      e_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= acc;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      e_v_q <= d1_v;
      g_v_q <= d2_v;
      h_v_q <= d3_v;
      i_v_q <= d4_v;
    end
  end

  // ---------------------------------------------------------------------------
  // result assembly; unused fields of each direction read zero
  // ---------------------------------------------------------------------------
  logic [OutDataW-1:0] res_data;
  logic                dir0;

  assign dir0 = !d6_side.func;

  assign res_data = {3'b000,
                     dir0 & tdf_q,
                     dir0 & drop_q,
                     dir0 ? d6_q[9:0]      : 10'd0,
                     dir0 ? d6_side.secs   : 6'd0,
                     dir0 ? d6_side.mins   : 6'd0,
                     dir0 ? d6_side.hours  : 20'd0,
                     dir0 & d6_side.neg,
                     dir0 ? 32'd0 : d6_side.cntw[31:0]};

  // ---------------------------------------------------------------------------
  // two-entry output buffer: output register plus spare
  // ---------------------------------------------------------------------------
  logic [OutDataW-1:0] out_data_q, spare_data_q;
  logic                push, pop;

  assign push = en && d6_v;
  assign pop  = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (spare_v_q) begin
      if (pop) begin
        spare_v_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        spare_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_v_q) begin
      if (pop) begin
        out_data_q <= spare_data_q;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_data_q <= res_data;
      end else begin
        spare_data_q <= res_data;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/tfc_div.sv =====
// pipelined restoring divider, one quotient bit per register stage
module tfc_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 39
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NW-1:0]       num_i,
  input  logic [DW-1:0]       den_i,
  input  tfc_pkg::side_t      side_i,
  output logic                valid_o,
  output logic [QW-1:0]       quo_o,
  output logic [DW-1:0]       rem_o,
  output tfc_pkg::side_t      side_o
);
  import tfc_pkg::*;

  // quotient must stay below 2**QW, so the top bits start below the divisor
  logic [QW-1:0] v_q;
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] nq_q   [QW];
  logic [DW-1:0] den_q  [QW];
  side_t         side_q [QW];

  logic [DW-1:0] r_in   [QW];
  logic [QW-1:0] nq_in  [QW];
  logic [DW-1:0] den_in [QW];
  logic [DW:0]   trial  [QW];
  logic [DW:0]   diff   [QW];
  logic [QW-1:0] ge;
  logic [DW-1:0] rem_d  [QW];
  logic [QW-1:0] nq_d   [QW];

  always_comb begin
    r_in[0]   = DW'(num_i[NW-1:QW]);
    nq_in[0]  = num_i[QW-1:0];
    den_in[0] = den_i;
    for (int k = 1; k < QW; k++) begin
      r_in[k]   = rem_q[k-1];
      nq_in[k]  = nq_q[k-1];
      den_in[k] = den_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k] = {r_in[k], nq_in[k][QW-1]};
      diff[k]  = trial[k] - {1'b0, den_in[k]};
      ge[k]    = (trial[k] >= {1'b0, den_in[k]});
      rem_d[k] = ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
      nq_d[k]  = {nq_in[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
        den_q[k] <= den_in[k];
      end
      for (int k = 1; k < QW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = nq_q[QW-1];
  assign rem_o   = rem_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== verif/timecode_frame_converter_unit_tb.sv =====
// self-checking testbench of the timecode frame converter: random and directed transfers
module timecode_frame_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfc_pkg::*;

  // one request as packed on s_axis_tdata/tuser
  typedef struct packed {
    logic        func;
    logic [9:0]  ff;
    logic [6:0]  ss;
    logic [6:0]  mm;
    logic [6:0]  hh;
    logic        tneg;
    logic [31:0] fc;
  } tc_req_t;

  // one result as packed on m_axis_tdata
  typedef struct packed {
    logic [2:0]  pad;
    logic        three_dig;
    logic        drop_sep;
    logic [9:0]  frames;
    logic [5:0]  secs;
    logic [5:0]  mins;
    logic [19:0] hours;
    logic        neg;
    logic [31:0] cnt;
  } tc_res_t;

  localparam int MaxGap   = 18;
  localparam int HoldLen  = 600;   // long receiver hold-off, in cycles
  localparam int Latency  = 160;   // settle time, a bit above the pipeline depth
  localparam int Watchdog = 20000;
  localparam longint CntMax = 2147483647;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  timecode_frame_converter_unit dut (.*);

  // shadow copy of the rate registers
  logic [19:0] rate_num = 20'd30;
  logic [15:0] rate_den = 16'd1;
  logic [9:0]  whole_fps = 10'd30;
  logic        drop_mode = 1'b0;
  logic [3:0]  drop_per_min = 4'd2;

  tc_req_t pending_reqs[$];
  tc_res_t expected_tc[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      gaps_on = 1'b1;
  bit      long_hold = 1'b0;
  int      hold_cnt = 0;
  int      send_gap = 0;
  int      recv_gap = 0;
  bit      in_xfer = 1'b0;
  bit      out_xfer = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    if (!gaps_on || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  // expected conversion for one request under the shadow registers
  function automatic tc_res_t tc_convert(tc_req_t q);
    tc_res_t o;
    logic [63:0] n, d, m, h, mi, s, t, secs, p, quo, rem;
    longint v, tm, r, hh, mm, ss, ff;
    o = '0;
    n = (rate_num == 0) ? 64'd1 : {44'd0, rate_num};
    d = (rate_den == 0) ? 64'd1 : {48'd0, rate_den};
    if (!q.func) begin
      // magnitude of the count; the most negative count stays 2^31
      m = q.fc[31] ? (64'h1_0000_0000 - {32'd0, q.fc}) : {32'd0, q.fc};
      h = (m * d) / (n * 3600);
      m = m - (h * 3600 * n) / d;
      mi = (m * d) / (n * 60);
      m = m - (mi * 60 * n) / d;
      s = (m * d) / n;
      t = s * n;
      // seconds are taken off with a ceiling step
      m = m - (t / d) - (((t % d) != 0) ? 64'd1 : 64'd0);
      o.neg = q.fc[31];
      o.hours = h[19:0];
      o.mins = mi[5:0];
      o.secs = s[5:0];
      o.frames = m[9:0];
      o.drop_sep = drop_mode;
      o.three_dig = (n > 100 * d);
    end else begin
      hh = longint'(q.hh);
      mm = longint'(q.mm);
      ss = longint'(q.ss);
      ff = longint'(q.ff);
      if (drop_mode) begin
        // whole rate, dropped frames on every minute but the tenth ones
        tm = 60 * hh + mm;
        r = longint'(whole_fps);
        v = r * 3600 * hh + r * 60 * mm + r * ss + ff - longint'(drop_per_min) * (tm - tm / 10);
      end else begin
        // exact rate, rounded half away from zero
        secs = q.hh * 3600 + q.mm * 60 + q.ss;
        p = secs * n;
        quo = p / d;
        rem = p % d;
        if (2 * rem >= d) quo = quo + 1;
        quo = quo + q.ff;
        if (quo > CntMax) quo = CntMax;
        v = longint'(quo);
      end
      if (v > CntMax) v = CntMax;
      if (v < -CntMax) v = -CntMax;
      if (q.tneg) v = -v;
      o.cnt = v[31:0];
    end
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] exp_val);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_val, $realtime);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val) report(what, got, exp_val);
  endtask

  // input side: a new item is put up only after the last one transferred
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_xfer)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        tc_req_t q;
        q = pending_reqs.pop_front();
        s_axis_tdata <= q[InDataW-1:0];
        s_axis_tuser <= q.func;
        s_axis_tvalid <= 1'b1;
        send_gap = draw_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    in_xfer = 1'b0;
  end

  // output side: random stalls plus one long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold && hold_cnt < HoldLen) begin
      hold_cnt++;
      m_axis_tready <= 1'b0;
    end else begin
      if (out_xfer) recv_gap = draw_gap();
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
    out_xfer = 1'b0;
  end

  // sample both transfers at the rising edge, check results, run the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tc_req_t q;
        q = {s_axis_tuser, s_axis_tdata};
        expected_tc.push_back(tc_convert(q));
        in_xfer = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tc_res_t got, exp_r;
        got = m_axis_tdata;
        out_xfer = 1'b1;
        if (expected_tc.size() == 0) begin
          report("unexpected result", got[63:0], 64'd0);
        end else begin
          exp_r = expected_tc.pop_front();
          check_field("frame_count_out", got.cnt, exp_r.cnt);
          check_field("out_negative", got.neg, exp_r.neg);
          check_field("out_hours", got.hours, exp_r.hours);
          check_field("out_minutes", got.mins, exp_r.mins);
          check_field("out_seconds", got.secs, exp_r.secs);
          check_field("out_frames", got.frames, exp_r.frames);
          check_field("drop_separator", got.drop_sep, exp_r.drop_sep);
          check_field("three_digit_frames", got.three_dig, exp_r.three_dig);
          check_field("pad bits", got.pad, exp_r.pad);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= Watchdog) begin
        $display("timecode_frame_converter_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FPS_NUM:      rate_num = val[19:0];
      CFG_FPS_DEN:      rate_den = val[15:0];
      CFG_ROUNDED_FPS:  whole_fps = val[9:0];
      CFG_DROP_FRAME:   drop_mode = val[0];
      CFG_DROP_PER_MIN: drop_per_min = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_rate(int num, int den, int whole, bit drop, int dpm);
    cfg_write(CFG_FPS_NUM, CfgDataW'(num));
    cfg_write(CFG_FPS_DEN, CfgDataW'(den));
    cfg_write(CFG_ROUNDED_FPS, CfgDataW'(whole));
    cfg_write(CFG_DROP_FRAME, CfgDataW'(drop));
    cfg_write(CFG_DROP_PER_MIN, CfgDataW'(dpm));
  endtask

  function automatic tc_req_t make_count(logic [31:0] fc);
    tc_req_t q;
    q = '0;
    q[63:0] = {$urandom, $urandom};
    q.func = 1'b0;
    q.fc = fc;
    return q;
  endfunction

  function automatic tc_req_t make_tc(bit neg, int hh, int mm, int ss, int ff);
    tc_req_t q;
    q.fc = $urandom;
    q.func = 1'b1;
    q.tneg = neg;
    q.hh = 7'(hh);
    q.mm = 7'(mm);
    q.ss = 7'(ss);
    q.ff = 10'(ff);
    return q;
  endfunction

  // random items: mostly in-range timecodes and counts, some full-width noise
  task automatic queue_random(int count);
    int fc;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: pending_reqs.push_back(make_count($urandom));
        1, 2: begin
          fc = $urandom_range(0, 400000);
          pending_reqs.push_back(make_count($urandom_range(0, 1) ? -fc : fc));
        end
        3: pending_reqs.push_back(make_tc(bit'($urandom_range(0, 1)), $urandom_range(0, 127),
                                          $urandom_range(0, 127), $urandom_range(0, 127),
                                          $urandom_range(0, 1023)));
        default: pending_reqs.push_back(make_tc(bit'($urandom_range(0, 1)),
                                                $urandom_range(0, 23),
                                                $urandom_range(0, 59), $urandom_range(0, 59),
                                                $urandom_range(0, 29)));
      endcase
    end
  endtask

  // sender waits here until every result is back and the pipeline is quiet
  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_tc.size() > 0)
      @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: 30/1, non-drop; directed corners first
    pending_reqs.push_back(make_count(32'd0));
    pending_reqs.push_back(make_count(32'd1));
    pending_reqs.push_back(make_count(32'hFFFF_FFFF));
    pending_reqs.push_back(make_count(32'h7FFF_FFFF));
    pending_reqs.push_back(make_count(32'h8000_0000));
    pending_reqs.push_back(make_count(32'd108000));
    pending_reqs.push_back(make_count(32'd107999));
    pending_reqs.push_back(make_count(-32'd1799));
    pending_reqs.push_back(make_tc(1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(make_tc(1'b1, 0, 0, 0, 0));
    pending_reqs.push_back(make_tc(1'b0, 99, 99, 99, 999));
    pending_reqs.push_back(make_tc(1'b1, 127, 127, 127, 1023));
    pending_reqs.push_back(make_tc(1'b1, 1, 2, 3, 4));
    queue_random(290);
    drain();

    // drop-frame at 30000/1001, directed tenth-minute cases
    set_rate(30000, 1001, 30, 1'b1, 2);
    pending_reqs.push_back(make_tc(1'b0, 0, 1, 0, 2));
    pending_reqs.push_back(make_tc(1'b0, 0, 10, 0, 0));
    pending_reqs.push_back(make_tc(1'b1, 99, 99, 99, 999));
    pending_reqs.push_back(make_count(32'h8000_0000));
    queue_random(160);
    drain();

    // zero rate registers count as one; long receiver hold-off fills the block
    set_rate(0, 0, 30, 1'b0, 2);
    long_hold = 1'b1;
    queue_random(170);
    drain();
    long_hold = 1'b0;

    // widest rate, non-drop, no idling
    gaps_on = 1'b0;
    set_rate(1048575, 1, 1000, 1'b0, 15);
    queue_random(170);
    drain();
    gaps_on = 1'b1;

    // slowest rate: wide split values wrap
    set_rate(1, 65535, 1, 1'b0, 0);
    queue_random(170);
    drain();

    // 120000/1001 drop-frame: three-digit frames
    set_rate(120000, 1001, 120, 1'b1, 8);
    queue_random(170);
    drain();

    // drop-frame with a zero whole rate goes below zero
    set_rate(25, 1, 0, 1'b1, 15);
    pending_reqs.push_back(make_tc(1'b0, 99, 99, 99, 0));
    pending_reqs.push_back(make_tc(1'b1, 99, 99, 99, 0));
    queue_random(80);
    drain();

    // largest whole rate, drop-frame count of the widest timecode
    set_rate(1000000, 7, 1023, 1'b1, 0);
    pending_reqs.push_back(make_tc(1'b0, 127, 127, 127, 1023));
    queue_random(120);
    drain();

    if (mismatches == 0)
      $display("timecode_frame_converter_unit regression: pass");
    else
      $display("timecode_frame_converter_unit regression: fail");
    $finish;
  end

endmodule
